/* rtl/sha_pkg.sv */
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// no dependencies
`default_nettype none
package sha_pkg;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        final_blk;
  } word_item_t;

  typedef enum logic [1:0] {F_IN, F_PAD80, F_PADZ, F_LEN} front_state_t;
  typedef enum logic [1:0] {B_RND, B_FIN, B_OUT} back_state_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage
`default_nettype wire

/* rtl/sha_if.sv */
// sha_if: byte input and digest output channel interfaces
// no dependencies
`default_nettype none
interface sha_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  modport source (output valid, data_byte, byte_valid, message_end, input ready);
  modport sink (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* rtl/sha256_stream_hasher_top.sv */
// sha256_stream_hasher_top: sha-256 over a byte stream, digest out as eight words
// depends on sha_pkg, sha_if, sha_front, sha_fifo, sha_back
//
// in_ch: one transaction per item, with an optional message byte and an end flag.
// out_ch: eight transactions per finished message, digest words 0..7, last_word
// high on word 7.
// the front takes one item per cycle while the word queue has room; it pads a
// finished message itself at one byte per cycle while the queue has room and
// holds in_ch.ready low meanwhile.
// the back runs one round per cycle: 64 rounds and then the chaining add per
// 64-byte block; the first 16 rounds take one queued word each and wait for it.
// with the default queue depth of 4 words the queue holds only 16 bytes while
// rounds 16..63 run, so the front stalls and in_ch.ready falls meanwhile.
// the first digest word appears in the cycle after the chaining add, and each
// word stays until out_ch accepts it; while out_ch stalls the back holds, the
// queue fills and in_ch.ready falls.
// reset (rst, synchronous) empties the queue and restarts at the initial hash.
`default_nettype none
module sha256_stream_hasher_top #(
  parameter int QueueDepth = sha_pkg::QueueDepth
) (
  input  wire logic     clk,
  input  wire logic     rst,
  sha_byte_if.sink      in_ch,
  sha_digest_if.source  out_ch
);

  sha_pkg::word_item_t push_item, pop_item;
  logic push, pop, full, empty;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_full(full), .q_push(push), .q_item(push_item)
  );

  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .pop_item(pop_item), .full(full), .empty(empty)
  );

  sha_back u_back (
    .clk(clk), .rst(rst), .q_item(pop_item), .q_empty(empty),
    .q_pop(pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

/* rtl/sha_front.sv */
// sha_front: takes bytes, pads messages and packs 32-bit words into the queue
// depends on sha_pkg and sha_if
`default_nettype none
module sha_front (
  input  wire logic         clk,
  input  wire logic         rst,
  sha_byte_if.sink          in_ch,
  input  wire logic         q_full,
  output logic              q_push,
  output sha_pkg::word_item_t q_item
);

  sha_pkg::front_state_t state, state_next;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [63:0] bits;
  logic        push_en;
  logic [7:0]  push_val;
  logic [63:0] len_shift;

  assign len_shift = bits << {fill[2:0], 3'b000};

  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::F_IN: begin
        if (in_ch.valid && !q_full && in_ch.message_end) state_next = sha_pkg::F_PAD80;
      end
      sha_pkg::F_PAD80: begin
        if (!q_full) state_next = (fill == sha_pkg::LenPos - 6'd1) ? sha_pkg::F_LEN
                                                                    : sha_pkg::F_PADZ;
      end
      sha_pkg::F_PADZ: begin
        if (!q_full && fill == sha_pkg::LenPos - 6'd1) state_next = sha_pkg::F_LEN;
      end
      sha_pkg::F_LEN: begin
        if (!q_full && fill == 6'd63) state_next = sha_pkg::F_IN;
      end
      default: state_next = sha_pkg::F_IN;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push_en = 1'b0;
    push_val = 8'd0;
    case (state)
      sha_pkg::F_IN: begin
        in_ch.ready = !q_full;
        push_en = in_ch.valid && !q_full && in_ch.byte_valid;
        push_val = in_ch.data_byte;
      end
      sha_pkg::F_PAD80: begin
        push_en = !q_full;
        push_val = sha_pkg::PadByte;
      end
      sha_pkg::F_PADZ: begin
        push_en = !q_full;
      end
      sha_pkg::F_LEN: begin
        push_en = !q_full;
        push_val = len_shift[63:56];
      end
      default: push_en = 1'b0;
    endcase
  end

  assign q_push = push_en && (fill[1:0] == 2'b11);
  assign q_item.word = {acc, push_val};
  assign q_item.final_blk = (state == sha_pkg::F_LEN) && (fill == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::F_IN;
      fill <= '0;
      bits <= '0;
    end else begin
      state <= state_next;
      if (push_en) fill <= fill + 6'd1;
      if (state == sha_pkg::F_IN && in_ch.valid && !q_full && in_ch.byte_valid)
        bits <= bits + 64'd8;
      else if (q_item.final_blk && push_en)
        bits <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) acc <= {acc[15:0], push_val};
  end

endmodule
`default_nettype wire

/* rtl/sha_fifo.sv */
// sha_fifo: short word queue between the front and the compression engine
// depends on sha_pkg
`default_nettype none
module sha_fifo #(
  parameter int Depth = sha_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  sha_pkg::word_item_t push_item,
  input  wire logic           pop,
  output sha_pkg::word_item_t pop_item,
  output logic                full,
  output logic                empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sha_pkg::word_item_t mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == LastPtr) ? '0 : wptr + PtrW'(1);
      if (pop) rptr <= (rptr == LastPtr) ? '0 : rptr + PtrW'(1);
      if (push && !pop) count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

endmodule
`default_nettype wire

/* rtl/sha_back.sv */
// sha_back: 64-round compression engine with rolling schedule and digest output
// depends on sha_pkg and sha_if
`default_nettype none
module sha_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  sha_pkg::word_item_t q_item,
  input  wire logic           q_empty,
  output logic                q_pop,
  sha_digest_if.source        out_ch
);

  sha_pkg::back_state_t state, state_next;
  logic [5:0]  t;
  logic [2:0]  idx;
  logic        final_q;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] win [16];
  logic        step;
  logic [31:0] w_cur, w_sched, t1, t2;

  assign w_sched = sha_pkg::ssig1(win[14]) + win[9] + sha_pkg::ssig0(win[1]) + win[0];
  assign w_cur = (t[5:4] == 2'b00) ? q_item.word : w_sched;
  assign q_pop = (state == sha_pkg::B_RND) && (t[5:4] == 2'b00) && !q_empty;
  assign step = (state == sha_pkg::B_RND) && ((t[5:4] != 2'b00) || !q_empty);
  assign t1 = v[7] + sha_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha_pkg::RoundK[t] + w_cur;
  assign t2 = sha_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::B_RND: if (step && t == 6'd63) state_next = sha_pkg::B_FIN;
      sha_pkg::B_FIN: state_next = final_q ? sha_pkg::B_OUT : sha_pkg::B_RND;
      sha_pkg::B_OUT: if (out_ch.ready && idx == 3'd7) state_next = sha_pkg::B_RND;
      default: state_next = sha_pkg::B_RND;
    endcase
  end

  always_comb begin
    out_ch.valid = (state == sha_pkg::B_OUT);
    out_ch.digest_word = chain[idx];
    out_ch.word_index = idx;
    out_ch.last_word = (idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::B_RND;
      t <= '0;
      idx <= '0;
      final_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha_pkg::InitHash[i];
        v[i] <= sha_pkg::InitHash[i];
      end
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::B_RND: begin
          if (step) begin
            t <= t + 6'd1;
            if (q_pop && t == 6'd15) final_q <= q_item.final_blk;
            v[0] <= t1 + t2;
            v[1] <= v[0];
            v[2] <= v[1];
            v[3] <= v[2];
            v[4] <= v[3] + t1;
            v[5] <= v[4];
            v[6] <= v[5];
            v[7] <= v[6];
          end
        end
        sha_pkg::B_FIN: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
            v[i] <= chain[i] + v[i];
          end
        end
        sha_pkg::B_OUT: begin
          if (out_ch.ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              final_q <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= sha_pkg::InitHash[i];
                v[i] <= sha_pkg::InitHash[i];
              end
            end
          end
        end
        default: t <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_cur;
    end
  end

endmodule
`default_nettype wire
